### src/rbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rectangle blit and fill engine package
// Shared types and constants for the raster engine: operation codes,
// register indexes, configuration and item records, and the walker state.
// ----------------------------------------------------------------------------
package rbf_pkg;

    // Fixed widths of the item and register fields.
    localparam int PIX_W    = 32;
    localparam int INDEX_W  = 16;
    localparam int COORD_W  = 12;
    localparam int DIM_W    = 13;
    localparam int BASE_W   = 16;
    localparam int PROD_W   = COORD_W + DIM_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // Wide enough for base + (y0 + rows) * pitch + (x0 + cols) at any legal size.
    localparam int ADDR_W   = 27;

    // Operation codes.
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_BLIT  = 2'd2,
        OP_FILL  = 2'd3
    } t_op;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_SRC_BASE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_PITCH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_BASE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_PITCH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_MODE = 3'd6;

    // Register reset values.
    localparam logic [DIM_W-1:0] RST_PITCH = 13'd256;
    localparam logic [DIM_W-1:0] RST_SIZE  = 13'd256;

    // Pixel mode codes.
    localparam logic MODE_8BIT  = 1'b0;
    localparam logic MODE_32BIT = 1'b1;

    // Walker sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN,
        ST_FLUSH,
        ST_DONE
    } t_state;

    // Configuration registers.
    typedef struct packed {
        logic [BASE_W-1:0] src_base;
        logic [DIM_W-1:0]  src_pitch;
        logic [BASE_W-1:0] dst_base;
        logic [DIM_W-1:0]  dst_pitch;
        logic [DIM_W-1:0]  dst_width;
        logic [DIM_W-1:0]  dst_height;
        logic              pixel_mode;
    } t_cfg;

    // Geometry of one input item.
    typedef struct packed {
        t_op                op;
        logic [INDEX_W-1:0] pixel_index;
        logic [COORD_W-1:0] src_x;
        logic [COORD_W-1:0] src_y;
        logic [DIM_W-1:0]   rect_width;
        logic [DIM_W-1:0]   rect_height;
        logic [COORD_W-1:0] dst_x;
        logic [COORD_W-1:0] dst_y;
    } t_item;

    // Walker status and the pixel it issues this cycle.
    typedef struct packed {
        logic              idle;
        logic              done;
        logic              issue;
        t_op               op;
        logic [ADDR_W-1:0] src_addr;
        logic [ADDR_W-1:0] dst_addr;
        logic              skip;
    } t_walk;

endpackage

### src/rbf_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel store
// Synchronous memory of one word per pixel with two registered read ports
// and one write port. Reads return the contents before a same-cycle write.
// ----------------------------------------------------------------------------
module rbf_store #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic                     i_clk,
    input  logic [AW-1:0]            i_rd_a_addr,
    input  logic [AW-1:0]            i_rd_b_addr,
    output logic [rbf_pkg::PIX_W-1:0] o_rd_a_data,
    output logic [rbf_pkg::PIX_W-1:0] o_rd_b_data,
    input  logic                     i_wr_en,
    input  logic [AW-1:0]            i_wr_addr,
    input  logic [rbf_pkg::PIX_W-1:0] i_wr_data
);

    logic [rbf_pkg::PIX_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Two read ports with registered data.
    always_ff @(posedge i_clk) begin
        o_rd_a_data <= mem[i_rd_a_addr];
        o_rd_b_data <= mem[i_rd_b_addr];
    end

endmodule

### src/rbf_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rectangle walker
// Sequencer that latches an item, works out its rectangle (saturation and
// fill clipping), and then issues one pixel address pair per cycle, row by
// row from the top and left to right within a row.
// ----------------------------------------------------------------------------
module rbf_walker #(
    parameter int STORE_DEPTH = 65536,
    parameter int MAX_DIM     = 4096
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  rbf_pkg::t_item i_item,
    input  rbf_pkg::t_cfg  i_cfg,
    input  logic           i_out_free,
    output rbf_pkg::t_walk o_walk
);

    localparam int CW = $clog2(MAX_DIM + 1);
    localparam int EW = ((CW > rbf_pkg::DIM_W) ? CW : rbf_pkg::DIM_W) + 1;
    localparam logic [rbf_pkg::ADDR_W-1:0] ADDR_LIMIT = rbf_pkg::ADDR_W'(STORE_DEPTH);

    rbf_pkg::t_state r_state, n_state;
    rbf_pkg::t_item  r_item, n_item;
    logic [CW-1:0]   r_w, n_w;
    logic [CW-1:0]   r_h, n_h;
    logic [CW-1:0]   r_col, n_col;
    logic [CW-1:0]   r_row, n_row;
    logic [rbf_pkg::ADDR_W-1:0] r_src_row, n_src_row;
    logic [rbf_pkg::ADDR_W-1:0] r_src_addr, n_src_addr;
    logic [rbf_pkg::ADDR_W-1:0] r_dst_row, n_dst_row;
    logic [rbf_pkg::ADDR_W-1:0] r_dst_addr, n_dst_addr;

    logic [CW-1:0]              w_sat;
    logic [CW-1:0]              h_sat;
    logic [EW-1:0]              x_end;
    logic [EW-1:0]              y_end;
    logic [rbf_pkg::DIM_W-1:0]  dx_ext;
    logic [rbf_pkg::DIM_W-1:0]  dy_ext;
    logic [CW-1:0]              fill_w;
    logic [CW-1:0]              fill_h;
    logic [CW-1:0]              set_w;
    logic [CW-1:0]              set_h;
    logic [rbf_pkg::PROD_W-1:0] src_mul;
    logic [rbf_pkg::PROD_W-1:0] dst_mul;
    logic [rbf_pkg::ADDR_W-1:0] src_start;
    logic [rbf_pkg::ADDR_W-1:0] dst_start;
    logic [rbf_pkg::ADDR_W-1:0] src_pitch_w;
    logic [rbf_pkg::ADDR_W-1:0] dst_pitch_w;
    logic                       src_oob;
    logic                       dst_oob;

    // Rectangle setup: saturate the size, clip a fill, and find the first pixel.
    always_comb begin
        w_sat = (32'(r_item.rect_width) > 32'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(r_item.rect_width);
        h_sat = (32'(r_item.rect_height) > 32'(MAX_DIM)) ? CW'(MAX_DIM)
                                                          : CW'(r_item.rect_height);
        dx_ext = rbf_pkg::DIM_W'(r_item.dst_x);
        dy_ext = rbf_pkg::DIM_W'(r_item.dst_y);
        x_end  = EW'(r_item.dst_x) + EW'(w_sat);
        y_end  = EW'(r_item.dst_y) + EW'(h_sat);

        fill_w = w_sat;
        if (x_end > EW'(i_cfg.dst_width)) begin
            fill_w = (i_cfg.dst_width > dx_ext) ? CW'(i_cfg.dst_width - dx_ext) : '0;
        end
        fill_h = h_sat;
        if (y_end > EW'(i_cfg.dst_height)) begin
            fill_h = (i_cfg.dst_height > dy_ext) ? CW'(i_cfg.dst_height - dy_ext) : '0;
        end

        src_mul = rbf_pkg::PROD_W'(r_item.src_y) * rbf_pkg::PROD_W'(i_cfg.src_pitch);
        dst_mul = rbf_pkg::PROD_W'(r_item.dst_y) * rbf_pkg::PROD_W'(i_cfg.dst_pitch);

        case (r_item.op)
            rbf_pkg::OP_BLIT: begin
                set_w     = w_sat;
                set_h     = h_sat;
                src_start = rbf_pkg::ADDR_W'(i_cfg.src_base) + rbf_pkg::ADDR_W'(src_mul)
                          + rbf_pkg::ADDR_W'(r_item.src_x);
                dst_start = rbf_pkg::ADDR_W'(i_cfg.dst_base) + rbf_pkg::ADDR_W'(dst_mul)
                          + rbf_pkg::ADDR_W'(r_item.dst_x);
            end
            rbf_pkg::OP_FILL: begin
                set_w     = fill_w;
                set_h     = fill_h;
                src_start = rbf_pkg::ADDR_W'(i_cfg.dst_base) + rbf_pkg::ADDR_W'(dst_mul)
                          + rbf_pkg::ADDR_W'(r_item.dst_x);
                dst_start = src_start;
            end
            default: begin
                // Single pixel read or write: one pixel at the given index.
                set_w     = CW'(1);
                set_h     = CW'(1);
                src_start = rbf_pkg::ADDR_W'(r_item.pixel_index);
                dst_start = rbf_pkg::ADDR_W'(r_item.pixel_index);
            end
        endcase
    end

    // Range checks on the current pixel.
    assign src_oob     = (r_src_addr >= ADDR_LIMIT);
    assign dst_oob     = (r_dst_addr >= ADDR_LIMIT);
    assign src_pitch_w = rbf_pkg::ADDR_W'(i_cfg.src_pitch);
    assign dst_pitch_w = rbf_pkg::ADDR_W'(i_cfg.dst_pitch);

    // Next state and issue.
    always_comb begin
        n_state    = r_state;
        n_item     = r_item;
        n_w        = r_w;
        n_h        = r_h;
        n_col      = r_col;
        n_row      = r_row;
        n_src_row  = r_src_row;
        n_src_addr = r_src_addr;
        n_dst_row  = r_dst_row;
        n_dst_addr = r_dst_addr;

        o_walk          = '0;
        o_walk.idle     = (r_state == rbf_pkg::ST_IDLE);
        o_walk.done     = (r_state == rbf_pkg::ST_DONE);
        o_walk.op       = r_item.op;
        o_walk.src_addr = r_src_addr;
        o_walk.dst_addr = r_dst_addr;
        o_walk.skip     = dst_oob || ((r_item.op != rbf_pkg::OP_FILL) && src_oob);

        case (r_state)
            rbf_pkg::ST_IDLE: begin
                if (i_accept) begin
                    n_item  = i_item;
                    n_state = rbf_pkg::ST_SETUP;
                end
            end
            rbf_pkg::ST_SETUP: begin
                n_w        = set_w;
                n_h        = set_h;
                n_col      = '0;
                n_row      = '0;
                n_src_row  = src_start;
                n_src_addr = src_start;
                n_dst_row  = dst_start;
                n_dst_addr = dst_start;
                n_state    = ((set_w == '0) || (set_h == '0)) ? rbf_pkg::ST_DONE
                                                              : rbf_pkg::ST_RUN;
            end
            rbf_pkg::ST_RUN: begin
                o_walk.issue = 1'b1;
                if (r_col == r_w - CW'(1)) begin
                    // End of a row: step both surfaces down one row.
                    n_col      = '0;
                    n_src_row  = r_src_row + src_pitch_w;
                    n_src_addr = r_src_row + src_pitch_w;
                    n_dst_row  = r_dst_row + dst_pitch_w;
                    n_dst_addr = r_dst_row + dst_pitch_w;
                    if (r_row == r_h - CW'(1)) begin
                        n_row   = '0;
                        n_state = rbf_pkg::ST_FLUSH;
                    end else begin
                        n_row = r_row + CW'(1);
                    end
                end else begin
                    n_col      = r_col + CW'(1);
                    n_src_addr = r_src_addr + rbf_pkg::ADDR_W'(1);
                    n_dst_addr = r_dst_addr + rbf_pkg::ADDR_W'(1);
                end
            end
            rbf_pkg::ST_FLUSH: begin
                // The last pixel finishes its write in this cycle.
                n_state = rbf_pkg::ST_DONE;
            end
            rbf_pkg::ST_DONE: begin
                if (i_out_free) begin
                    n_state = rbf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rbf_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rbf_pkg::ST_IDLE;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
        end
    end

    // Item and address registers.
    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_w        <= n_w;
        r_h        <= n_h;
        r_src_row  <= n_src_row;
        r_src_addr <= n_src_addr;
        r_dst_row  <= n_dst_row;
        r_dst_addr <= n_dst_addr;
    end

endmodule

### src/rect_blit_and_fill_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rectangle blit and fill engine
// A 2D raster engine over a word-per-pixel store: single pixel write and
// read, rectangle copy between surfaces, and clipped rectangle fill.
// ----------------------------------------------------------------------------
// One item is worked at a time. A single pixel write or read passes through
// setup, one memory access, write back and result, and the engine takes the
// next item once the result is in the output register. A blit or fill goes
// through the same steps and issues one pixel per cycle of its rectangle; an
// empty rectangle goes from setup straight to its result. The pixel rate is
// set by the store, which does one read-modify-write per cycle: each pixel
// reads its source and destination words, merges them (the low byte only for
// a blit or fill in 8-bit mode) and writes the destination in the following
// cycle, with the written word forwarded to the next pixel when it reads the
// same entry. The store is not cleared at reset; its contents are undefined
// until written. A finished result waits in the output register while the
// next item is taken; while that register is held by a stalled receiver, the
// following result waits in the engine and the input stalls. Configuration
// writes are always ready and are to be made only while the engine is idle.
// ----------------------------------------------------------------------------
module rect_blit_and_fill_engine_unit #(
    parameter int STORE_DEPTH = 65536,
    parameter int MAX_DIM     = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input item channel.
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_operation,
    input  logic [rbf_pkg::INDEX_W-1:0]     i_pixel_index,
    input  logic [rbf_pkg::PIX_W-1:0]       i_pixel_value,
    input  logic [rbf_pkg::COORD_W-1:0]     i_src_x,
    input  logic [rbf_pkg::COORD_W-1:0]     i_src_y,
    input  logic [rbf_pkg::DIM_W-1:0]       i_rect_width,
    input  logic [rbf_pkg::DIM_W-1:0]       i_rect_height,
    input  logic [rbf_pkg::COORD_W-1:0]     i_dst_x,
    input  logic [rbf_pkg::COORD_W-1:0]     i_dst_y,
    // Result channel.
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [rbf_pkg::PIX_W-1:0]       o_read_data,
    output logic                            o_fault,
    // Configuration write channel.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rbf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rbf_pkg::CFG_DAT_W-1:0]   i_cfg_data
);

    localparam int AW = $clog2(STORE_DEPTH);

    rbf_pkg::t_cfg  r_cfg, n_cfg;
    rbf_pkg::t_item in_item;
    rbf_pkg::t_walk walk;

    logic                      in_accept;
    logic                      out_free;
    logic                      out_load;
    logic [rbf_pkg::PIX_W-1:0] r_pval;

    // Pixel stage: the pixel whose memory reads are returning this cycle.
    logic                      r_p_valid;
    rbf_pkg::t_op              r_p_op;
    logic [AW-1:0]             r_p_dst;
    logic                      r_p_skip;
    logic                      r_p_fwd_src;
    logic                      r_p_fwd_dst;
    logic [rbf_pkg::PIX_W-1:0] r_fwd_data;

    logic [rbf_pkg::PIX_W-1:0] mem_a_data;
    logic [rbf_pkg::PIX_W-1:0] mem_b_data;
    logic [rbf_pkg::PIX_W-1:0] src_word;
    logic [rbf_pkg::PIX_W-1:0] dst_word;
    logic [rbf_pkg::PIX_W-1:0] new_value;
    logic [rbf_pkg::PIX_W-1:0] wr_data;
    logic                      full_word;
    logic                      wr_en;

    // Result accumulation and output register.
    logic                      r_fault_acc;
    logic [rbf_pkg::PIX_W-1:0] r_rdata_acc;
    logic                      r_out_valid;
    logic [rbf_pkg::PIX_W-1:0] r_read_data;
    logic                      r_fault;

    // Handshakes.
    assign in_accept   = i_in_valid && walk.idle;
    assign o_in_stall  = !walk.idle;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign out_load    = walk.done && out_free;
    assign o_cfg_ready = 1'b1;

    // Configuration register writes; data is trimmed to each register's width.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                rbf_pkg::REG_SRC_BASE:   n_cfg.src_base   = i_cfg_data;
                rbf_pkg::REG_SRC_PITCH:  n_cfg.src_pitch  = i_cfg_data[rbf_pkg::DIM_W-1:0];
                rbf_pkg::REG_DST_BASE:   n_cfg.dst_base   = i_cfg_data;
                rbf_pkg::REG_DST_PITCH:  n_cfg.dst_pitch  = i_cfg_data[rbf_pkg::DIM_W-1:0];
                rbf_pkg::REG_DST_WIDTH:  n_cfg.dst_width  = i_cfg_data[rbf_pkg::DIM_W-1:0];
                rbf_pkg::REG_DST_HEIGHT: n_cfg.dst_height = i_cfg_data[rbf_pkg::DIM_W-1:0];
                rbf_pkg::REG_PIXEL_MODE: n_cfg.pixel_mode = i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_base   <= '0;
            r_cfg.src_pitch  <= rbf_pkg::RST_PITCH;
            r_cfg.dst_base   <= '0;
            r_cfg.dst_pitch  <= rbf_pkg::RST_PITCH;
            r_cfg.dst_width  <= rbf_pkg::RST_SIZE;
            r_cfg.dst_height <= rbf_pkg::RST_SIZE;
            r_cfg.pixel_mode <= rbf_pkg::MODE_32BIT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Item geometry goes to the walker; the pixel value stays here.
    always_comb begin
        in_item.op          = rbf_pkg::t_op'(i_operation);
        in_item.pixel_index = i_pixel_index;
        in_item.src_x       = i_src_x;
        in_item.src_y       = i_src_y;
        in_item.rect_width  = i_rect_width;
        in_item.rect_height = i_rect_height;
        in_item.dst_x       = i_dst_x;
        in_item.dst_y       = i_dst_y;
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_pval <= i_pixel_value;
        end
    end

    rbf_walker #(
        .STORE_DEPTH (STORE_DEPTH),
        .MAX_DIM     (MAX_DIM)
    ) u_walker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_accept),
        .i_item     (in_item),
        .i_cfg      (r_cfg),
        .i_out_free (out_free),
        .o_walk     (walk)
    );

    rbf_store #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk       (i_clk),
        .i_rd_a_addr (walk.src_addr[AW-1:0]),
        .i_rd_b_addr (walk.dst_addr[AW-1:0]),
        .o_rd_a_data (mem_a_data),
        .o_rd_b_data (mem_b_data),
        .i_wr_en     (wr_en),
        .i_wr_addr   (r_p_dst),
        .i_wr_data   (wr_data)
    );

    // Merge: take the forwarded word where the previous pixel just wrote the entry.
    always_comb begin
        src_word  = r_p_fwd_src ? r_fwd_data : mem_a_data;
        dst_word  = r_p_fwd_dst ? r_fwd_data : mem_b_data;
        new_value = ((r_p_op == rbf_pkg::OP_BLIT) || (r_p_op == rbf_pkg::OP_READ)) ? src_word
                                                                                   : r_pval;
        full_word = (r_p_op == rbf_pkg::OP_WRITE) || (r_p_op == rbf_pkg::OP_READ)
                 || (r_cfg.pixel_mode == rbf_pkg::MODE_32BIT);
        wr_data   = full_word ? new_value : {dst_word[rbf_pkg::PIX_W-1:8], new_value[7:0]};
        wr_en     = r_p_valid && !r_p_skip && (r_p_op != rbf_pkg::OP_READ);
    end

    // Pixel stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= walk.issue;
        end
    end

    // Pixel stage payload and forwarding flags.
    always_ff @(posedge i_clk) begin
        r_p_op      <= walk.op;
        r_p_dst     <= walk.dst_addr[AW-1:0];
        r_p_skip    <= walk.skip;
        r_p_fwd_src <= wr_en && (walk.src_addr[AW-1:0] == r_p_dst);
        r_p_fwd_dst <= wr_en && (walk.dst_addr[AW-1:0] == r_p_dst);
        r_fwd_data  <= wr_data;
    end

    // Fault and read data gathered over the item, cleared when the result moves to the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault_acc <= 1'b0;
            r_rdata_acc <= '0;
        end else if (out_load) begin
            r_fault_acc <= 1'b0;
            r_rdata_acc <= '0;
        end else if (r_p_valid) begin
            if (r_p_skip) begin
                r_fault_acc <= 1'b1;
            end else if (r_p_op == rbf_pkg::OP_READ) begin
                r_rdata_acc <= src_word;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_read_data <= r_rdata_acc;
            r_fault     <= r_fault_acc;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_read_data;
    assign o_fault     = r_fault;

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rectangle blit and fill engine testbench
// Drives pixel writes, reads, blits and fills through the item channel and
// programs the surface registers between phases. A mirror of the pixel store
// and the registers predicts every result beat, and a checker compares each
// beat taken from the result channel against the oldest prediction. Directed
// cases come first, then random phases under several surface settings, with
// random idling and stalls on both channels.
// ----------------------------------------------------------------------------
module tb;

    localparam int STORE_DEPTH    = 65536;
    localparam int MAX_DIM        = 4096;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 300000;
    localparam int PHASE_ITEMS    = 200;

    // One raster command as the sender offers it.
    typedef struct {
        rbf_pkg::t_op                op;
        logic [rbf_pkg::INDEX_W-1:0] pixel_index;
        logic [rbf_pkg::PIX_W-1:0]   pixel_value;
        logic [rbf_pkg::COORD_W-1:0] src_x;
        logic [rbf_pkg::COORD_W-1:0] src_y;
        logic [rbf_pkg::DIM_W-1:0]   rect_width;
        logic [rbf_pkg::DIM_W-1:0]   rect_height;
        logic [rbf_pkg::COORD_W-1:0] dst_x;
        logic [rbf_pkg::COORD_W-1:0] dst_y;
    } t_raster_cmd;

    // One predicted result beat.
    typedef struct {
        logic [rbf_pkg::PIX_W-1:0] read_data;
        logic                      fault;
    } t_raster_result;

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          i_in_valid    = 1'b0;
    logic                          o_in_stall;
    logic [1:0]                    i_operation   = '0;
    logic [rbf_pkg::INDEX_W-1:0]   i_pixel_index = '0;
    logic [rbf_pkg::PIX_W-1:0]     i_pixel_value = '0;
    logic [rbf_pkg::COORD_W-1:0]   i_src_x       = '0;
    logic [rbf_pkg::COORD_W-1:0]   i_src_y       = '0;
    logic [rbf_pkg::DIM_W-1:0]     i_rect_width  = '0;
    logic [rbf_pkg::DIM_W-1:0]     i_rect_height = '0;
    logic [rbf_pkg::COORD_W-1:0]   i_dst_x       = '0;
    logic [rbf_pkg::COORD_W-1:0]   i_dst_y       = '0;
    logic                          o_out_valid;
    logic                          i_out_stall   = 1'b0;
    logic [rbf_pkg::PIX_W-1:0]     o_read_data;
    logic                          o_fault;
    logic                          i_cfg_valid   = 1'b0;
    logic                          o_cfg_ready;
    logic [rbf_pkg::CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [rbf_pkg::CFG_DAT_W-1:0] i_cfg_data    = '0;

    // Mirror of the engine state.
    logic [rbf_pkg::PIX_W-1:0] pixel_mem [0:STORE_DEPTH-1];
    rbf_pkg::t_cfg             surface_cfg;
    t_raster_result            expected_q [$];

    int errors       = 0;
    int idle_cycles  = 0;
    bit idle_on      = 1'b1;
    bit hold_request = 1'b0;
    int hold_left    = 0;

    rect_blit_and_fill_engine_unit #(
        .STORE_DEPTH (STORE_DEPTH),
        .MAX_DIM     (MAX_DIM)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_pixel_index (i_pixel_index),
        .i_pixel_value (i_pixel_value),
        .i_src_x       (i_src_x),
        .i_src_y       (i_src_y),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .i_dst_x       (i_dst_x),
        .i_dst_y       (i_dst_y),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_read_data   (o_read_data),
        .o_fault       (o_fault),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Free-running clock, 10 ns period.
    always #5 i_clk = ~i_clk;

    // Destination word after a blit or fill pixel lands on it.
    function automatic logic [rbf_pkg::PIX_W-1:0] merge_px(
        input logic [rbf_pkg::PIX_W-1:0] old_px,
        input logic [rbf_pkg::PIX_W-1:0] new_px);
        if (surface_cfg.pixel_mode == rbf_pkg::MODE_8BIT) begin
            return {old_px[rbf_pkg::PIX_W-1:8], new_px[7:0]};
        end
        return new_px;
    endfunction

    // Works one command on the mirror store and queues the result it causes.
    task automatic apply_raster_op(input t_raster_cmd c);
        t_raster_result r;
        int             rw;
        int             rh;
        int             w;
        int             h;
        longint         sa;
        longint         da;
        r.read_data = '0;
        r.fault     = 1'b0;
        rw = (c.rect_width > MAX_DIM) ? MAX_DIM : int'(c.rect_width);
        rh = (c.rect_height > MAX_DIM) ? MAX_DIM : int'(c.rect_height);
        case (c.op)
            rbf_pkg::OP_WRITE: begin
                if (longint'(c.pixel_index) < STORE_DEPTH) begin
                    pixel_mem[c.pixel_index] = c.pixel_value;
                end else begin
                    r.fault = 1'b1;
                end
            end
            rbf_pkg::OP_READ: begin
                if (longint'(c.pixel_index) < STORE_DEPTH) begin
                    r.read_data = pixel_mem[c.pixel_index];
                end else begin
                    r.fault = 1'b1;
                end
            end
            rbf_pkg::OP_BLIT: begin
                // Row by row from the top, left to right, reading the store as it stands.
                for (int row = 0; row < rh; row++) begin
                    for (int col = 0; col < rw; col++) begin
                        sa = longint'(surface_cfg.src_base)
                           + (longint'(c.src_y) + row) * longint'(surface_cfg.src_pitch)
                           + longint'(c.src_x) + col;
                        da = longint'(surface_cfg.dst_base)
                           + (longint'(c.dst_y) + row) * longint'(surface_cfg.dst_pitch)
                           + longint'(c.dst_x) + col;
                        if (sa >= STORE_DEPTH || da >= STORE_DEPTH) begin
                            r.fault = 1'b1;
                        end else begin
                            pixel_mem[da] = merge_px(pixel_mem[da], pixel_mem[sa]);
                        end
                    end
                end
            end
            default: begin
                // Fill clips its right and bottom edges to the destination size.
                w = rw;
                h = rh;
                if (int'(c.dst_x) + w > int'(surface_cfg.dst_width)) begin
                    w = int'(surface_cfg.dst_width) - int'(c.dst_x);
                end
                if (int'(c.dst_y) + h > int'(surface_cfg.dst_height)) begin
                    h = int'(surface_cfg.dst_height) - int'(c.dst_y);
                end
                for (int row = 0; row < h; row++) begin
                    for (int col = 0; col < w; col++) begin
                        da = longint'(surface_cfg.dst_base)
                           + (longint'(c.dst_y) + row) * longint'(surface_cfg.dst_pitch)
                           + longint'(c.dst_x) + col;
                        if (da >= STORE_DEPTH) begin
                            r.fault = 1'b1;
                        end else begin
                            pixel_mem[da] = merge_px(pixel_mem[da], c.pixel_value);
                        end
                    end
                end
            end
        endcase
        expected_q.push_back(r);
    endtask

    function automatic t_raster_cmd mk_cmd(input rbf_pkg::t_op op,
                                           input logic [rbf_pkg::INDEX_W-1:0] idx,
                                           input logic [rbf_pkg::PIX_W-1:0] val,
                                           input logic [rbf_pkg::COORD_W-1:0] sx,
                                           input logic [rbf_pkg::COORD_W-1:0] sy,
                                           input logic [rbf_pkg::DIM_W-1:0] w,
                                           input logic [rbf_pkg::DIM_W-1:0] h,
                                           input logic [rbf_pkg::COORD_W-1:0] dx,
                                           input logic [rbf_pkg::COORD_W-1:0] dy);
        t_raster_cmd c;
        c.op          = op;
        c.pixel_index = idx;
        c.pixel_value = val;
        c.src_x       = sx;
        c.src_y       = sy;
        c.rect_width  = w;
        c.rect_height = h;
        c.dst_x       = dx;
        c.dst_y       = dy;
        return c;
    endfunction

    // Random command: mostly small rectangles near the top-left surface corner, a few
    // with a full-range side, and single accesses often aimed at the
    // destination area so that reads see what blits and fills left behind.
    function automatic t_raster_cmd random_cmd();
        t_raster_cmd c;
        int unsigned pick;
        c.op          = rbf_pkg::t_op'($urandom_range(0, 3));
        c.pixel_index = $urandom;
        c.pixel_value = $urandom;
        c.src_x       = $urandom;
        c.src_y       = $urandom;
        c.dst_x       = $urandom;
        c.dst_y       = $urandom;
        c.rect_width  = $urandom;
        c.rect_height = $urandom;
        if (c.op == rbf_pkg::OP_WRITE || c.op == rbf_pkg::OP_READ) begin
            if ($urandom_range(0, 1) == 1) begin
                c.pixel_index = surface_cfg.dst_base
                              + rbf_pkg::INDEX_W'($urandom_range(0, 1023));
            end
        end else begin
            if ($urandom_range(0, 4) != 0) begin
                c.src_x = $urandom_range(0, 15);
                c.src_y = $urandom_range(0, 15);
                c.dst_x = $urandom_range(0, 15);
                c.dst_y = $urandom_range(0, 15);
            end
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                c.rect_height = $urandom_range(0, 2);
            end else if (pick < 4) begin
                c.rect_width = $urandom_range(0, 2);
            end else begin
                c.rect_width  = $urandom_range(0, 8);
                c.rect_height = $urandom_range(0, 8);
            end
        end
        return c;
    endfunction

    // Offers one command beat and waits until the engine takes it. Returns at
    // the next falling edge with valid still high.
    task automatic send_cmd(input t_raster_cmd c);
        if (idle_on && $urandom_range(0, 99) < 10) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_operation   <= c.op;
        i_pixel_index <= c.pixel_index;
        i_pixel_value <= c.pixel_value;
        i_src_x       <= c.src_x;
        i_src_y       <= c.src_y;
        i_rect_width  <= c.rect_width;
        i_rect_height <= c.rect_height;
        i_dst_x       <= c.dst_x;
        i_dst_y       <= c.dst_y;
        do @(posedge i_clk); while (o_in_stall);
        apply_raster_op(c);
        @(negedge i_clk);
    endtask

    // Stops offering commands and waits until every predicted beat has come.
    task automatic wait_results();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [rbf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rbf_pkg::CFG_DAT_W-1:0] data, input bit last);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            rbf_pkg::REG_SRC_BASE:   surface_cfg.src_base   = data[rbf_pkg::BASE_W-1:0];
            rbf_pkg::REG_SRC_PITCH:  surface_cfg.src_pitch  = data[rbf_pkg::DIM_W-1:0];
            rbf_pkg::REG_DST_BASE:   surface_cfg.dst_base   = data[rbf_pkg::BASE_W-1:0];
            rbf_pkg::REG_DST_PITCH:  surface_cfg.dst_pitch  = data[rbf_pkg::DIM_W-1:0];
            rbf_pkg::REG_DST_WIDTH:  surface_cfg.dst_width  = data[rbf_pkg::DIM_W-1:0];
            rbf_pkg::REG_DST_HEIGHT: surface_cfg.dst_height = data[rbf_pkg::DIM_W-1:0];
            rbf_pkg::REG_PIXEL_MODE: surface_cfg.pixel_mode = data[0];
            default: ;
        endcase
        @(negedge i_clk);
        if (last) begin
            i_cfg_valid <= 1'b0;
        end
    endtask

    // Programs every surface register; only called while the engine is idle.
    task automatic load_surface(input logic [15:0] sb, input logic [15:0] sp,
                                input logic [15:0] db, input logic [15:0] dp,
                                input logic [15:0] dw, input logic [15:0] dh,
                                input logic mode);
        write_reg(rbf_pkg::REG_SRC_BASE,   sb, 1'b0);
        write_reg(rbf_pkg::REG_SRC_PITCH,  sp, 1'b0);
        write_reg(rbf_pkg::REG_DST_BASE,   db, 1'b0);
        write_reg(rbf_pkg::REG_DST_PITCH,  dp, 1'b0);
        write_reg(rbf_pkg::REG_DST_WIDTH,  dw, 1'b0);
        write_reg(rbf_pkg::REG_DST_HEIGHT, dh, 1'b0);
        write_reg(rbf_pkg::REG_PIXEL_MODE, {15'd0, mode}, 1'b1);
    endtask

    // Reset register values: a full-surface fill covers the whole store, so
    // nothing read later is left unwritten. Then a one-pixel blit uses the
    // reset source surface.
    task automatic test_reset_values();
        send_cmd(mk_cmd(rbf_pkg::OP_FILL, 0, $urandom, 0, 0, 256, 256, 0, 0));
        send_cmd(mk_cmd(rbf_pkg::OP_READ, 16'h0000, 0, 0, 0, 0, 0, 0, 0));
        send_cmd(mk_cmd(rbf_pkg::OP_READ, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0));
        send_cmd(mk_cmd(rbf_pkg::OP_WRITE, 5, 32'h1357_9BDF, 0, 0, 0, 0, 0, 0));
        send_cmd(mk_cmd(rbf_pkg::OP_BLIT, 0, 0, 5, 0, 1, 1, 7, 3));
        send_cmd(mk_cmd(rbf_pkg::OP_READ, 7 + 3 * 256, 0, 0, 0, 0, 0, 0, 0));
        wait_results();
    endtask

    // Single pixel write and read at the index extremes; in 8-bit mode they
    // still move the whole word.
    task automatic test_single_pixel();
        send_cmd(mk_cmd(rbf_pkg::OP_WRITE, 16'h0000, 32'h0000_0000, 0, 0, 0, 0, 0, 0));
        send_cmd(mk_cmd(rbf_pkg::OP_WRITE, 16'hFFFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0));
        send_cmd(mk_cmd(rbf_pkg::OP_READ, 16'h0000, 0, 0, 0, 0, 0, 0, 0));
        send_cmd(mk_cmd(rbf_pkg::OP_READ, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0));
        wait_results();
        load_surface(0, 256, 0, 256, 256, 256, rbf_pkg::MODE_8BIT);
        send_cmd(mk_cmd(rbf_pkg::OP_WRITE, 16'h1234, 32'hA5A5_5A5A, 0, 0, 0, 0, 0, 0));
        send_cmd(mk_cmd(rbf_pkg::OP_READ, 16'h1234, 0, 0, 0, 0, 0, 0, 0));
        wait_results();
    endtask

    task automatic test_blit();
        // Plain copy between two surfaces.
        load_surface(16'h0100, 16, 16'h2000, 32, 32, 32, rbf_pkg::MODE_32BIT);
        send_cmd(mk_cmd(rbf_pkg::OP_BLIT, 0, 0, 1, 2, 4, 3, 3, 4));
        send_cmd(mk_cmd(rbf_pkg::OP_READ, 16'h2000 + 4 * 32 + 3, 0, 0, 0, 0, 0, 0, 0));
        // Zero-sized rectangle copies nothing.
        send_cmd(mk_cmd(rbf_pkg::OP_BLIT, 0, 0, 0, 0, 0, 5, 0, 0));
        wait_results();
        // Overlapping copy one pixel to the right smears the first pixel, low byte only.
        load_surface(16'h3000, 16, 16'h3000, 16, 16, 16, rbf_pkg::MODE_8BIT);
        send_cmd(mk_cmd(rbf_pkg::OP_BLIT, 0, 0, 0, 0, 6, 2, 1, 0));
        send_cmd(mk_cmd(rbf_pkg::OP_READ, 16'h3003, 0, 0, 0, 0, 0, 0, 0));
        wait_results();
        // Zero pitch folds every row onto the same store row.
        load_surface(16'h4000, 0, 16'h4100, 0, 64, 64, rbf_pkg::MODE_32BIT);
        send_cmd(mk_cmd(rbf_pkg::OP_BLIT, 0, 0, 1, 0, 3, 5, 2, 0));
        send_cmd(mk_cmd(rbf_pkg::OP_READ, 16'h4102, 0, 0, 0, 0, 0, 0, 0));
        wait_results();
        // Source running off the end of the store, then an oversized width.
        load_surface(16'hFFF0, 4096, 16'h1000, 4096, 4096, 4096, rbf_pkg::MODE_32BIT);
        send_cmd(mk_cmd(rbf_pkg::OP_BLIT, 0, 0, 12, 0, 4, 4, 0, 0));
        send_cmd(mk_cmd(rbf_pkg::OP_BLIT, 0, 0, 0, 0, 13'h1FFF, 1, 0, 2));
        send_cmd(mk_cmd(rbf_pkg::OP_READ, 16'h1000 + 2 * 4096 + 5, 0, 0, 0, 0, 0, 0, 0));
        wait_results();
    endtask

    task automatic test_fill();
        load_surface(0, 256, 16'h5000, 64, 40, 30, rbf_pkg::MODE_32BIT);
        // Clipped on the right and at the bottom.
        send_cmd(mk_cmd(rbf_pkg::OP_FILL, 0, $urandom, 0, 0, 10, 10, 35, 25));
        // Corner past the right edge, then exactly on it: nothing is filled.
        send_cmd(mk_cmd(rbf_pkg::OP_FILL, 0, $urandom, 0, 0, 5, 5, 45, 0));
        send_cmd(mk_cmd(rbf_pkg::OP_FILL, 0, $urandom, 0, 0, 5, 5, 40, 0));
        // Oversized rectangle saturates and clips to the whole surface.
        send_cmd(mk_cmd(rbf_pkg::OP_FILL, 0, $urandom, 0, 0, 13'h1FFF, 13'h1FFF, 0, 0));
        send_cmd(mk_cmd(rbf_pkg::OP_READ, 16'h5000 + 29 * 64 + 39, 0, 0, 0, 0, 0, 0, 0));
        wait_results();
        // 8-bit fill that runs off the end of the store.
        load_surface(0, 256, 16'hFF00, 64, 64, 64, rbf_pkg::MODE_8BIT);
        send_cmd(mk_cmd(rbf_pkg::OP_FILL, 0, 32'h1122_33C4, 0, 0, 8, 8, 0, 0));
        send_cmd(mk_cmd(rbf_pkg::OP_READ, 16'hFF41, 0, 0, 0, 0, 0, 0, 0));
        wait_results();
    endtask

    // The receiver holds off while commands keep coming, so the engine backs
    // up and stalls its input; then the sender waits for every result.
    task automatic test_backpressure();
        t_raster_cmd c;
        load_surface(0, 256, 16'h8000, 256, 256, 256, rbf_pkg::MODE_32BIT);
        hold_request = 1'b1;
        for (int n = 0; n < 16; n++) begin
            c    = random_cmd();
            c.op = ($urandom_range(0, 1) == 1) ? rbf_pkg::OP_READ : rbf_pkg::OP_WRITE;
            send_cmd(c);
        end
        wait_results();
    endtask

    task automatic run_phase(input int count);
        for (int n = 0; n < count; n++) begin
            send_cmd(random_cmd());
        end
        wait_results();
    endtask

    // Random commands under several surface settings, the extremes among them.
    task automatic test_random();
        logic [15:0] base;
        load_surface(0, 256, 16'h8000, 256, 256, 256, rbf_pkg::MODE_32BIT);
        run_phase(PHASE_ITEMS);
        load_surface($urandom, $urandom_range(1, 4096), $urandom, $urandom_range(1, 4096),
                     $urandom_range(1, 4096), $urandom_range(1, 4096), rbf_pkg::MODE_8BIT);
        run_phase(PHASE_ITEMS);
        load_surface(16'hFFFF, 4096, 16'hFFFF, 4096, 4096, 4096, rbf_pkg::MODE_8BIT);
        run_phase(PHASE_ITEMS);
        load_surface(0, 1, 0, 1, 1, 1, rbf_pkg::MODE_32BIT);
        run_phase(PHASE_ITEMS);
        // Shared surface so that copies overlap, with no idling on either side.
        base = $urandom_range(0, 16'hF000);
        idle_on = 1'b0;
        load_surface(base, 32, base, 32, 64, 64, 1'($urandom_range(0, 1)));
        run_phase(PHASE_ITEMS);
        idle_on = 1'b1;
        load_surface($urandom, $urandom_range(1, 4096), $urandom, $urandom_range(1, 4096),
                     $urandom_range(1, 4096), $urandom_range(1, 4096),
                     1'($urandom_range(0, 1)));
        run_phase(PHASE_ITEMS);
    endtask

    // Result side: random stalls, or a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= idle_on && ($urandom_range(0, 99) < 10);
        end
    end

    // Compare each result beat with the oldest prediction.
    always @(posedge i_clk) begin : check_beat
        t_raster_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                $error("result beat with nothing expected: read_data %h fault %b",
                       o_read_data, o_fault);
                errors++;
            end else begin
                want = expected_q.pop_front();
                if (o_read_data !== want.read_data) begin
                    $error("read_data expected %h actual %h", want.read_data, o_read_data);
                    errors++;
                end
                if (o_fault !== want.fault) begin
                    $error("fault expected %b actual %b", want.fault, o_fault);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles in which no beat moves on any channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        surface_cfg = '{src_base: '0, src_pitch: rbf_pkg::RST_PITCH, dst_base: '0,
                        dst_pitch: rbf_pkg::RST_PITCH, dst_width: rbf_pkg::RST_SIZE,
                        dst_height: rbf_pkg::RST_SIZE, pixel_mode: rbf_pkg::MODE_32BIT};
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_values();
        test_single_pixel();
        test_blit();
        test_fill();
        test_backpressure();
        test_random();

        wait_results();
        repeat (20) @(posedge i_clk);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
